>>> sv/lpst_pkg.sv
package lpst_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int KIND_W    = 2;
	localparam int PAGE_W    = 32;
	localparam int SLOT_F_W  = 6;
	localparam int OUT_D_W   = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_TOUCH = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		UPD_NONE    = 2'd0,
		UPD_PROMOTE = 2'd1,
		UPD_INSERT  = 2'd2,
		UPD_REMOVE  = 2'd3
	} upd_mode_t;

	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
	} fs_ctl_t;

endpackage

>>> sv/lpst_rank_alu.sv
module lpst_rank_alu #(
	parameter int RW = 6
) (
	input  lpst_pkg::upd_mode_t mode,
	input  logic                in_use,
	input  logic                is_tgt,
	input  logic [RW-1:0]       old_rank,
	input  logic [RW-1:0]       ref_rank,
	output logic [RW-1:0]       new_rank
);
	import lpst_pkg::*;

	always_comb begin
		new_rank = old_rank;
		case (mode)
			UPD_PROMOTE: begin
				if (is_tgt)
					new_rank = '0;
				else if (in_use && (old_rank < ref_rank))
					new_rank = old_rank + RW'(1);
			end
			UPD_INSERT: begin
				if (is_tgt)
					new_rank = '0;
				else if (in_use)
					new_rank = old_rank + RW'(1);
			end
			UPD_REMOVE: begin
				if (!is_tgt && in_use && (old_rank > ref_rank))
					new_rank = old_rank - RW'(1);
			end
			default: begin
				new_rank = old_rank;
			end
		endcase
	end

endmodule

>>> sv/lpst_free_stack.sv
module lpst_free_stack #(
	parameter int SLOTS = lpst_pkg::SLOTS_DEF,
	parameter int SW    = 6,
	parameter int CW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpst_pkg::fs_ctl_t ctl,
	input  logic [SW-1:0]     push_slot,
	output logic              empty,
	output logic [SW-1:0]     top_slot
);
	import lpst_pkg::*;

	logic [SW-1:0]    mem [SLOTS];
	logic [CW-1:0]    fc_q;
	logic [SLOTS-1:0] written_q;
	logic [CW-1:0]    fc_dec;
	logic [SW-1:0]    rd_idx;
	logic [SW-1:0]    push_idx;
	logic             full;
	logic [SW-1:0]    rd_data_s1;
	logic [SW-1:0]    rd_idx_s1;
	logic             rd_wr_s1;

	assign fc_dec   = fc_q - CW'(1);
	assign rd_idx   = fc_dec[SW-1:0];
	assign push_idx = fc_q[SW-1:0];
	assign full     = (fc_q == CW'(SLOTS));
	assign empty    = (fc_q == '0);
	// entries never pushed still hold their reset order
	assign top_slot = rd_wr_s1 ? rd_data_s1 : (SW'(SLOTS - 1) - rd_idx_s1);

	always_ff @(posedge clk) begin
		if (ctl.push && !full)
			mem[push_idx] <= push_slot;
		if (ctl.rd)
			rd_data_s1 <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= CW'(SLOTS);
			written_q <= '0;
			rd_idx_s1 <= '0;
			rd_wr_s1  <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rd_idx_s1 <= rd_idx;
				rd_wr_s1  <= written_q[rd_idx];
			end
			if (ctl.pop && !empty) begin
				fc_q <= fc_q - CW'(1);
			end else if (ctl.push && !full) begin
				fc_q                <= fc_q + CW'(1);
				written_q[push_idx] <= 1'b1;
			end
		end
	end

endmodule

>>> sv/lru_page_slot_table.sv
// Fully associative page-to-slot table with LRU replacement and a LIFO free-slot
// stack. Each request (kind in s_axis_tuser, page id in s_axis_tdata) yields one
// result transfer. A request walks the tag/rank memories once to find the page
// and the LRU slot, passes through a decide state, and, when ranks change
// (allocate, resident touch and resident free), walks the rank memory once more
// to rewrite them, then posts the result. Query and non-resident touch/free skip
// the second walk. The block is ready again once the result is posted. The
// memory walks read one entry per cycle. One request is in flight at a time;
// the next is taken while the result waits in the output register, and it
// stalls before posting until that result is transferred.
module lru_page_slot_table #(
	parameter int SLOTS = lpst_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [lpst_pkg::PAGE_W-1:0]    s_axis_tdata,  // [31:0] page_id
	input  logic [lpst_pkg::KIND_W-1:0]    s_axis_tuser,  // [1:0] kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [lpst_pkg::OUT_D_W-1:0]   m_axis_tdata,  // [0] hit, [6:1] slot,
	                                                      // [38:7] evicted_page, [39] zero
	output logic [0:0]                     m_axis_tuser   // [0] evicted_valid
);
	import lpst_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = SW;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [SW:0]       cnt_q;
	logic              rd_vld_s1;
	logic [SW-1:0]     rd_idx_s1;
	logic [PAGE_W-1:0] tag_rd_s1;
	logic [RW-1:0]     rank_rd_s1;
	logic [PAGE_W-1:0] tag_mem  [SLOTS];
	logic [RW-1:0]     rank_mem [SLOTS];
	logic [SLOTS-1:0]  in_use_q;

	kind_t             kind_q;
	logic [PAGE_W-1:0] page_q;
	logic              hit_q;
	logic [SW-1:0]     match_q;
	logic [RW-1:0]     mrank_q;
	logic [SW-1:0]     lru_q;
	logic [PAGE_W-1:0] lru_tag_q;
	upd_mode_t         mode_q;
	logic [SW-1:0]     tgt_q;
	logic [RW-1:0]     ref_q;
	logic [SW-1:0]     fin_slot_q;
	logic              fin_ev_q;

	logic              m_tvalid_q;
	logic              res_hit_q;
	logic [SW-1:0]     res_slot_q;
	logic              res_ev_q;
	logic [PAGE_W-1:0] res_evpage_q;

	logic              s_acc;
	logic              mem_re;
	logic [SW-1:0]     rd_addr;
	logic              scan_done;
	logic              cur_in_use;
	logic [RW-1:0]     new_rank;
	logic              rank_we;
	fs_ctl_t           fs_ctl;
	logic              fs_empty;
	logic [SW-1:0]     fs_top;

	upd_mode_t         d_mode;
	logic [SW-1:0]     d_tgt;
	logic [RW-1:0]     d_ref;
	logic              d_ev;
	logic              d_slot;
	logic              d_tag_we;
	logic              tag_we;
	logic [SW+5:0]     slot_ext;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign mem_re        = ((state_q == ST_SCAN) || (state_q == ST_UPD))
	                       && (cnt_q < (SW+1)'(SLOTS));
	assign rd_addr       = cnt_q[SW-1:0];
	assign scan_done     = (cnt_q == (SW+1)'(SLOTS));
	assign cur_in_use    = in_use_q[rd_idx_s1];
	assign rank_we       = (state_q == ST_UPD) && rd_vld_s1;
	assign tag_we        = (state_q == ST_DECIDE) && d_tag_we;

	always_comb begin
		d_mode   = UPD_NONE;
		d_tgt    = match_q;
		d_ref    = mrank_q;
		d_ev     = 1'b0;
		d_slot   = 1'b0;
		d_tag_we = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				d_slot = 1'b1;
				if (hit_q) begin
					d_mode = UPD_PROMOTE;
				end else if (!fs_empty) begin
					d_mode   = UPD_INSERT;
					d_tgt    = fs_top;
					d_tag_we = 1'b1;
				end else begin
					// evicted slot holds the oldest rank, so a promote refreshes it
					d_mode   = UPD_PROMOTE;
					d_tgt    = lru_q;
					d_ref    = RW'(SLOTS - 1);
					d_ev     = 1'b1;
					d_tag_we = 1'b1;
				end
			end
			KIND_TOUCH: begin
				if (hit_q)
					d_mode = UPD_PROMOTE;
			end
			KIND_FREE: begin
				if (hit_q) begin
					d_mode = UPD_REMOVE;
					d_slot = 1'b1;
				end
			end
			default: begin
				d_mode = UPD_NONE;
			end
		endcase
	end

	always_comb begin
		fs_ctl.rd   = s_acc;
		fs_ctl.pop  = (state_q == ST_DECIDE) && (kind_q == KIND_ALLOC) && !hit_q && !fs_empty;
		fs_ctl.push = (state_q == ST_DECIDE) && (kind_q == KIND_FREE) && hit_q;
	end

	lpst_free_stack #(
		.SLOTS (SLOTS),
		.SW    (SW),
		.CW    (CW)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fs_ctl),
		.push_slot (match_q),
		.empty     (fs_empty),
		.top_slot  (fs_top)
	);

	lpst_rank_alu #(
		.RW (RW)
	) u_rank_alu (
		.mode     (mode_q),
		.in_use   (cur_in_use),
		.is_tgt   (rd_idx_s1 == tgt_q),
		.old_rank (rank_rd_s1),
		.ref_rank (ref_q),
		.new_rank (new_rank)
	);

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[d_tgt] <= page_q;
		if (rank_we)
			rank_mem[rd_idx_s1] <= new_rank;
		if (mem_re) begin
			tag_rd_s1  <= tag_mem[rd_addr];
			rank_rd_s1 <= rank_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			in_use_q     <= '0;
			kind_q       <= KIND_ALLOC;
			page_q       <= '0;
			hit_q        <= 1'b0;
			match_q      <= '0;
			mrank_q      <= '0;
			lru_q        <= '0;
			lru_tag_q    <= '0;
			mode_q       <= UPD_NONE;
			tgt_q        <= '0;
			ref_q        <= '0;
			fin_slot_q   <= '0;
			fin_ev_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
			res_hit_q    <= 1'b0;
			res_slot_q   <= '0;
			res_ev_q     <= 1'b0;
			res_evpage_q <= '0;
		end else begin
			rd_vld_s1 <= mem_re;
			rd_idx_s1 <= rd_addr;
			if (m_axis_tready && (state_q != ST_FIN))
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						kind_q  <= kind_t'(s_axis_tuser);
						page_q  <= s_axis_tdata;
						hit_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_re)
						cnt_q <= cnt_q + (SW+1)'(1);
					if (rd_vld_s1 && cur_in_use) begin
						if (tag_rd_s1 == page_q) begin
							hit_q   <= 1'b1;
							match_q <= rd_idx_s1;
							mrank_q <= rank_rd_s1;
						end
						if (rank_rd_s1 == RW'(SLOTS - 1)) begin
							lru_q     <= rd_idx_s1;
							lru_tag_q <= tag_rd_s1;
						end
					end
					if (scan_done)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					mode_q     <= d_mode;
					tgt_q      <= d_tgt;
					ref_q      <= d_ref;
					fin_slot_q <= d_slot ? d_tgt : '0;
					fin_ev_q   <= d_ev;
					if (d_mode == UPD_INSERT)
						in_use_q[d_tgt] <= 1'b1;
					else if (d_mode == UPD_REMOVE)
						in_use_q[d_tgt] <= 1'b0;
					cnt_q   <= '0;
					state_q <= (d_mode == UPD_NONE) ? ST_FIN : ST_UPD;
				end
				ST_UPD: begin
					if (mem_re)
						cnt_q <= cnt_q + (SW+1)'(1);
					if (scan_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q   <= 1'b1;
						res_hit_q    <= hit_q;
						res_slot_q   <= fin_slot_q;
						res_ev_q     <= fin_ev_q;
						res_evpage_q <= fin_ev_q ? lru_tag_q : '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign slot_ext      = {6'b0, res_slot_q};
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {1'b0, res_evpage_q, slot_ext[SLOT_F_W-1:0], res_hit_q};
	assign m_axis_tuser  = res_ev_q;

endmodule

>>> sv/lpst_chk.sv
module lpst_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [lpst_pkg::PAGE_W-1:0]  s_axis_tdata,
	input logic [lpst_pkg::KIND_W-1:0]  s_axis_tuser,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [lpst_pkg::OUT_D_W-1:0] m_axis_tdata,
	input logic [0:0]                   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while waiting");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[0])
		else $error("eviction reported on a hit");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[38:7] == '0))
		else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_slot_table lpst_chk u_lpst_chk (.*);

>>> tb/sv/tb_lru_page_slot_table.sv
module tb_lru_page_slot_table;
	import lpst_pkg::*;

	localparam int NSLOT    = SLOTS_DEF;
	localparam int POOL_SZ  = 72;
	localparam int CLK_HALF = 4;
	localparam int HOLD_CYC = 4 * (2 * NSLOT + 4);

	typedef struct packed {
		logic        hit;
		logic [5:0]  slot;
		logic        ev_valid;
		logic [31:0] ev_page;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PAGE_W-1:0]   s_axis_tdata = '0;
	logic [KIND_W-1:0]   s_axis_tuser = KIND_ALLOC;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_D_W-1:0]  m_axis_tdata;
	logic [0:0]          m_axis_tuser;

	// page table mirror
	logic [31:0] shadow_tag [NSLOT];
	bit          shadow_busy [NSLOT];
	int          shadow_rank [NSLOT];
	int          free_slots [NSLOT];
	int          free_depth;

	logic [31:0] page_pool [POOL_SZ];
	answer_t     table_answers [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_go = 1'b0;
	bit hold_on = 1'b0;
	int err_count = 0;
	int n_sent = 0;
	int n_seen = 0;
	int n_hit = 0;
	int n_evict = 0;
	int n_freed = 0;

	lru_page_slot_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(2 * CLK_HALF * 1000000);
		$display("status: fail");
		$finish;
	end

	// long receiver hold-off, counted in cycles
	initial begin
		wait (hold_go);
		hold_on <= 1'b1;
		for (hold_left = HOLD_CYC; hold_left > 0; hold_left--)
			@(posedge clk);
		hold_on <= 1'b0;
	end

	function automatic void make_newest(int s);
		int i;
		int r;
		r = shadow_rank[s];
		for (i = 0; i < NSLOT; i++)
			if (shadow_busy[i] && i != s && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	function automatic void retire_slot(int s);
		int i;
		int r;
		r = shadow_rank[s];
		shadow_busy[s] = 0;
		for (i = 0; i < NSLOT; i++)
			if (shadow_busy[i] && shadow_rank[i] > r)
				shadow_rank[i]--;
	endfunction

	function automatic answer_t resolve_request(kind_t k, logic [31:0] pg);
		answer_t a;
		int s;
		int i;
		a = '0;
		s = -1;
		for (i = 0; i < NSLOT; i++)
			if (s < 0 && shadow_busy[i] && shadow_tag[i] == pg)
				s = i;
		a.hit = (s >= 0);
		case (k)
			KIND_ALLOC: begin
				if (s >= 0) begin
					make_newest(s);
				end else begin
					if (free_depth > 0) begin
						free_depth--;
						s = free_slots[free_depth];
					end else begin
						// table full: oldest page goes
						for (i = 0; i < NSLOT; i++)
							if (shadow_busy[i] && shadow_rank[i] == NSLOT - 1)
								s = i;
						a.ev_valid = 1'b1;
						a.ev_page = shadow_tag[s];
						retire_slot(s);
					end
					for (i = 0; i < NSLOT; i++)
						if (shadow_busy[i])
							shadow_rank[i]++;
					shadow_busy[s] = 1;
					shadow_tag[s] = pg;
					shadow_rank[s] = 0;
				end
				a.slot = s[5:0];
			end
			KIND_TOUCH: begin
				if (s >= 0)
					make_newest(s);
			end
			KIND_FREE: begin
				if (s >= 0) begin
					retire_slot(s);
					free_slots[free_depth] = s;
					free_depth++;
					a.slot = s[5:0];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on result %0d, %s: got 0x%h want 0x%h",
			$time, n_seen, what, got, want);
		err_count++;
	endtask

	task automatic send_req(kind_t k, logic [31:0] pg);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			s_axis_tuser <= KIND_W'($urandom_range(0, 3));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pg;
		s_axis_tuser <= k;
		do
			@(posedge clk);
		while (!s_axis_tready);
		table_answers.insert(table_answers.size(), resolve_request(k, pg));
		n_sent++;
	endtask

	// result side: stall control and checking
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_seen++;
			if (table_answers.size() == 0) begin
				report_mismatch("transfer with nothing pending", m_axis_tdata[31:0], '0);
			end else begin
				want = table_answers.pop_front();
				if (m_axis_tdata[0] !== want.hit)
					report_mismatch("hit", 32'(m_axis_tdata[0]), 32'(want.hit));
				if (m_axis_tdata[6:1] !== want.slot)
					report_mismatch("slot", 32'(m_axis_tdata[6:1]), 32'(want.slot));
				if (m_axis_tuser[0] !== want.ev_valid)
					report_mismatch("evicted_valid", 32'(m_axis_tuser[0]),
						32'(want.ev_valid));
				if (m_axis_tdata[38:7] !== want.ev_page)
					report_mismatch("evicted_page", m_axis_tdata[38:7], want.ev_page);
				if (m_axis_tdata[39] !== 1'b0)
					report_mismatch("pad bit", 32'(m_axis_tdata[39]), '0);
				n_hit += want.hit;
				n_evict += want.ev_valid;
			end
		end
		if (hold_on)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic test_directed();
		send_req(KIND_ALLOC, 32'h0000_0000);
		send_req(KIND_ALLOC, 32'hFFFF_FFFF);
		send_req(KIND_ALLOC, 32'h0000_0000);
		send_req(KIND_QUERY, 32'h0000_0000);
		send_req(KIND_QUERY, 32'h1234_5678);
		send_req(KIND_TOUCH, 32'hFFFF_FFFF);
		send_req(KIND_TOUCH, 32'hA5A5_A5A5);
		send_req(KIND_FREE,  32'h0000_0000);
		send_req(KIND_FREE,  32'h0000_0000);
		send_req(KIND_QUERY, 32'h0000_0000);
		send_req(KIND_ALLOC, 32'h5A5A_5A5A);
		send_req(KIND_FREE,  32'hFFFF_FFFF);
		send_req(KIND_FREE,  32'h5A5A_5A5A);
		send_req(KIND_ALLOC, 32'h8000_0000);
		send_req(KIND_ALLOC, 32'h0000_0001);
		send_req(KIND_TOUCH, 32'h8000_0000);
		send_req(KIND_QUERY, 32'hFFFF_FFFF);
		send_req(KIND_FREE,  32'h8000_0000);
		send_req(KIND_FREE,  32'h0000_0001);
	endtask

	// fill every slot from the pool, then keep allocating to force evictions
	task automatic test_fill_and_evict();
		int i;
		for (i = 0; i < POOL_SZ; i++) begin
			send_req(KIND_ALLOC, page_pool[i]);
			if (i % 9 == 0)
				send_req(KIND_TOUCH, page_pool[$urandom_range(0, i)]);
		end
	endtask

	task automatic test_backpressure();
		int i;
		hold_go = 1'b1;
		for (i = 0; i < 6; i++)
			send_req(KIND_ALLOC, page_pool[$urandom_range(0, POOL_SZ - 1)]);
	endtask

	// release the whole pool in random order so its pages go back onto the free stack
	task automatic test_drain();
		int order [POOL_SZ];
		int i;
		for (i = 0; i < POOL_SZ; i++)
			order[i] = i;
		order.shuffle();
		for (i = 0; i < POOL_SZ; i++)
			send_req(KIND_FREE, page_pool[order[i]]);
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
		int i;
		int r;
		kind_t k;
		logic [31:0] pg;
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				k = KIND_ALLOC;
			else if (r < 65)
				k = KIND_TOUCH;
			else if (r < 80)
				k = KIND_FREE;
			else
				k = KIND_QUERY;
			if ($urandom_range(0, 9) == 0)
				pg = $urandom;
			else
				pg = page_pool[$urandom_range(0, POOL_SZ - 1)];
			send_req(k, pg);
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NSLOT; i++) begin
			shadow_busy[i] = 0;
			shadow_rank[i] = 0;
			shadow_tag[i] = '0;
			free_slots[i] = NSLOT - 1 - i;
		end
		free_depth = NSLOT;
		page_pool[0] = 32'h0000_0000;
		page_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < POOL_SZ; i++)
			page_pool[i] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_evict();
		test_backpressure();
		test_random_traffic(60, 0, 0);
		test_drain();
		test_random_traffic(60, 69, 0);
		test_random_traffic(60, 0, 69);
		test_random_traffic(60, 13, 13);

		s_axis_tvalid <= 1'b0;
		while (table_answers.size() != 0)
			@(posedge clk);
		repeat (2 * NSLOT + 8) @(posedge clk);

		$display("covered %0d requests over four idle/stall mixes plus a long output hold-off",
			n_sent);
		$display("results checked %0d: %0d hits, %0d evictions", n_seen, n_hit, n_evict);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/lpst_pkg.sv
sv/lpst_rank_alu.sv
sv/lpst_free_stack.sv
sv/lru_page_slot_table.sv
sv/lpst_chk.sv
tb/sv/tb_lru_page_slot_table.sv
